@@ design/qws_pkg.sv @@
package qws_pkg;

	localparam logic [7:0] CH_SQ  = 8'h27;
	localparam logic [7:0] CH_DQ  = 8'h22;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ESCAPE   = 3'd1,
		ST_DANGLING = 3'd2,
		ST_OPEN_SQ  = 3'd3,
		ST_OPEN_DQ  = 3'd4
	} status_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       word_end;
		logic       line_done;
		status_t    status;
	} result_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

@@ design/qws_in_if.sv @@
interface qws_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       line_last;

	modport source (output valid, output in_char, output line_last, input ready);
	modport sink (input valid, input in_char, input line_last, output ready);
endinterface

@@ design/qws_out_if.sv @@
interface qws_out_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [7:0] out_char;
	logic       word_end;
	logic       line_done;
	logic [2:0] status;

	modport source (
		output valid, output char_valid, output out_char, output word_end,
		output line_done, output status, input ready
	);
	modport sink (
		input valid, input char_valid, input out_char, input word_end,
		input line_done, input status, output ready
	);
endinterface

@@ design/qws_lexer.sv @@
module qws_lexer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       in_char,
	input  logic             line_last,
	output qws_pkg::result_t res
);
	import qws_pkg::*;

	typedef enum logic [2:0] {
		M_NONE = 3'd0,
		M_WORD = 3'd1,
		M_BSL  = 3'd2,
		M_SQ   = 3'd3,
		M_DQ   = 3'd4
	} mode_t;

	mode_t   mode_q, mode_d;
	logic    failed_q, failed_d;
	status_t first_error_q, first_error_d;

	always_comb begin
		mode_d        = mode_q;
		failed_d      = failed_q;
		first_error_d = first_error_q;
		res           = '0;

		if (!failed_q) begin
			case (mode_q)
				M_WORD: begin
					if (in_char == CH_SQ) mode_d = M_SQ;
					else if (in_char == CH_DQ) mode_d = M_DQ;
					else if (in_char == CH_BSL) mode_d = M_BSL;
					else if (is_blank(in_char)) begin
						res.word_end = 1'b1;
						mode_d       = M_NONE;
					end else begin
						res.char_valid = 1'b1;
						res.out_char   = in_char;
					end
				end
				M_BSL: begin
					if ((in_char == CH_SP) || (in_char == CH_BSL)) begin
						mode_d         = M_WORD;
						res.char_valid = 1'b1;
						res.out_char   = in_char;
					end else begin
						failed_d      = 1'b1;
						first_error_d = ST_ESCAPE;
					end
				end
				M_SQ: begin
					if (in_char == CH_SQ) mode_d = M_WORD;
					else begin
						res.char_valid = 1'b1;
						res.out_char   = in_char;
					end
				end
				M_DQ: begin
					if (in_char == CH_DQ) mode_d = M_WORD;
					else begin
						res.char_valid = 1'b1;
						res.out_char   = in_char;
					end
				end
				default: begin
					if (in_char == CH_SQ) mode_d = M_SQ;
					else if (in_char == CH_DQ) mode_d = M_DQ;
					else if (in_char == CH_BSL) mode_d = M_BSL;
					else if (!is_blank(in_char)) begin
						mode_d         = M_WORD;
						res.char_valid = 1'b1;
						res.out_char   = in_char;
					end else mode_d = M_NONE;
				end
			endcase
		end

		// close the line: report status, then drop back to reset state
		if (line_last) begin
			res.line_done = 1'b1;
			if (failed_d) begin
				res.status = first_error_d;
			end else begin
				case (mode_d)
					M_WORD:  res.word_end = 1'b1;
					M_BSL:   res.status = ST_DANGLING;
					M_SQ:    res.status = ST_OPEN_SQ;
					M_DQ:    res.status = ST_OPEN_DQ;
					default: res.status = ST_OK;
				endcase
			end
			mode_d        = M_NONE;
			failed_d      = 1'b0;
			first_error_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= M_NONE;
			failed_q      <= 1'b0;
			first_error_q <= ST_OK;
		end else if (step) begin
			mode_q        <= mode_d;
			failed_q      <= failed_d;
			first_error_q <= first_error_d;
		end
	end

`ifndef SYNTH
	a_line_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && line_last |=> (mode_q == M_NONE) && !failed_q && (first_error_q == ST_OK))
		else $error("state not cleared after line end");
	a_failed_code: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> (first_error_q == ST_ESCAPE))
		else $error("failed set without escape code");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(failed_q))
		else $error("state moved without a step");
	a_failed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> !res.char_valid && !res.word_end)
		else $error("output produced after error");
`endif
endmodule

@@ design/quoted_word_splitter.sv @@
// Shell-style word splitter for a command line, one byte per request.
// Channel item (sink): in_char and line_last, line_last set on the final
// byte. Channel result (source): one result per byte with char_valid and
// out_char (a character appended to the current word), word_end (word
// complete; with no character since the previous mark it is an empty
// word), line_done on the final byte, and status valid with line_done
// (ok, unknown escape, dangling backslash, open single or double quote).
// After an error the rest of the line gives empty results and the final
// byte reports the code; the consumer discards that line.
// Each accepted byte passes through one input register and one result register;
// the lexer between them works out the result from the byte and the word mode.
// Throughput: one byte per cycle while the receiver takes results; the lexer steps on each byte.
// Reset clears the word mode, the error flag and both pipeline stages.
// When the receiver stalls, the result register holds, the input register
// holds one more byte, and then item.ready drops until result.ready returns.
module quoted_word_splitter (
	input  logic      clk,
	input  logic      arst_n,
	qws_in_if.sink    item,
	qws_out_if.source result
);
	import qws_pkg::*;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res_next;
	logic       advance;
	logic       step;

	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) valid_s1 <= item.valid;
			if (advance) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			char_s1 <= item.in_char;
			last_s1 <= item.line_last;
		end
		if (step) res_s2 <= res_next;
	end

	qws_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_char   (char_s1),
		.line_last (last_s1),
		.res       (res_next)
	);

	assign result.valid      = valid_s2;
	assign result.char_valid = res_s2.char_valid;
	assign result.out_char   = res_s2.out_char;
	assign result.word_end   = res_s2.word_end;
	assign result.line_done  = res_s2.line_done;
	assign result.status     = res_s2.status;
endmodule

@@ verif/quoted_word_splitter_tb.sv @@
module quoted_word_splitter_tb;
	import qws_pkg::*;

	localparam int RANDOM_ITEMS   = 1300;
	localparam int LONG_HOLD      = 120;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES    = 6;

	typedef enum logic [2:0] {
		LX_IDLE = 3'd0,
		LX_WORD = 3'd1,
		LX_ESC  = 3'd2,
		LX_SQ   = 3'd3,
		LX_DQ   = 3'd4
	} lex_mode_t;

	class word_split_board_t;
		lex_mode_t mode;
		bit        failed;
		status_t   first_err;
		result_t   expected_q[$];
		int        n_checked;
		int        n_fail;
		int        n_words;
		int        n_bad_lines;

		function new();
			clear_line();
		endfunction

		static function bit is_ws(logic [7:0] c);
			return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
		endfunction

		function void clear_line();
			mode = LX_IDLE;
			failed = 1'b0;
			first_err = ST_OK;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// predict the result of one accepted request
		function void note_request(logic [7:0] c, logic last);
			result_t r;
			r = '0;
			r.status = ST_OK;
			if (!failed) begin
				case (mode)
					LX_WORD: begin
						if (c == CH_SQ) mode = LX_SQ;
						else if (c == CH_DQ) mode = LX_DQ;
						else if (c == CH_BSL) mode = LX_ESC;
						else if (is_ws(c)) begin
							r.word_end = 1'b1;
							mode = LX_IDLE;
						end else begin
							r.char_valid = 1'b1;
							r.out_char = c;
						end
					end
					LX_ESC: begin
						if (c == CH_SP || c == CH_BSL) begin
							mode = LX_WORD;
							r.char_valid = 1'b1;
							r.out_char = c;
						end else begin
							failed = 1'b1;
							first_err = ST_ESCAPE;
						end
					end
					LX_SQ, LX_DQ: begin
						if (c == ((mode == LX_SQ) ? CH_SQ : CH_DQ)) mode = LX_WORD;
						else begin
							r.char_valid = 1'b1;
							r.out_char = c;
						end
					end
					default: begin
						if (c == CH_SQ) mode = LX_SQ;
						else if (c == CH_DQ) mode = LX_DQ;
						else if (c == CH_BSL) mode = LX_ESC;
						else if (!is_ws(c)) begin
							mode = LX_WORD;
							r.char_valid = 1'b1;
							r.out_char = c;
						end else mode = LX_IDLE;
					end
				endcase
			end
			if (last) begin
				r.line_done = 1'b1;
				if (failed) r.status = first_err;
				else begin
					case (mode)
						LX_WORD: r.word_end = 1'b1;
						LX_ESC:  r.status = ST_DANGLING;
						LX_SQ:   r.status = ST_OPEN_SQ;
						LX_DQ:   r.status = ST_OPEN_DQ;
						default: ;
					endcase
				end
				if (r.status != ST_OK) n_bad_lines++;
				clear_line();
			end
			if (r.word_end) n_words++;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function void check_result(logic cv, logic [7:0] oc, logic we, logic ld,
			logic [2:0] st);
			result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no request pending");
				n_fail++;
				return;
			end
			want = expected_q.pop_front();
			n_checked++;
			if (cv !== want.char_valid) begin
				$error("char_valid: expected %0b, got %0b", want.char_valid, cv);
				n_fail++;
			end
			if (oc !== want.out_char) begin
				$error("out_char: expected %h, got %h", want.out_char, oc);
				n_fail++;
			end
			if (we !== want.word_end) begin
				$error("word_end: expected %0b, got %0b", want.word_end, we);
				n_fail++;
			end
			if (ld !== want.line_done) begin
				$error("line_done: expected %0b, got %0b", want.line_done, ld);
				n_fail++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				n_fail++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	qws_in_if  item_if();
	qws_out_if result_if();

	quoted_word_splitter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	word_split_board_t board = new();

	logic [7:0] line_buf[$];
	int n_accepted   = 0;
	int n_lines      = 0;
	int burst_left   = 0;
	int hold_req_cnt = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int rx_cycle     = 0;
	int rx_style     = 0;
	int idle_cycles  = 0;
	bit hold_done    = 1'b0;
	bit drain_done   = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_if.valid && item_if.ready) begin
				board.note_request(item_if.in_char, item_if.line_last);
				n_accepted <= n_accepted + 1;
			end
			if (result_if.valid && result_if.ready)
				board.check_result(result_if.char_valid, result_if.out_char,
					result_if.word_end, result_if.line_done, result_if.status);
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("quoted_word_splitter verification failed");
			$finish;
		end
	end

	// receiver: switch stall style now and then, hold off long on request
	always @(posedge clk) begin
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			result_if.ready <= 1'b0;
		end else if (hold_seen != hold_req_cnt) begin
			hold_seen = hold_req_cnt;
			hold_left = LONG_HOLD;
			result_if.ready <= 1'b0;
		end else begin
			if (rx_cycle % 160 == 0) rx_style = $urandom_range(0, 2);
			case (rx_style)
				0: result_if.ready <= 1'b1;
				1: result_if.ready <= ($urandom_range(0, 3) != 0);
				default: result_if.ready <= ((rx_cycle % 7) >= 2);
			endcase
		end
	end

	function automatic void put_byte(logic [7:0] c);
		line_buf.insert(line_buf.size(), c);
	endfunction

	task automatic send_byte(logic [7:0] c, logic last);
		int gap;
		item_if.valid <= 1'b1;
		item_if.in_char <= c;
		item_if.line_last <= last;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
		if (burst_left > 0) burst_left--;
		else begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				item_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	task automatic flush_line();
		int i;
		for (i = 0; i < line_buf.size(); i++)
			send_byte(line_buf[i], i == line_buf.size() - 1);
		line_buf.delete();
		n_lines++;
	endtask

	function automatic logic [7:0] blank_byte();
		logic [7:0] c;
		c = ($urandom_range(0, 1) != 0) ? CH_SP : CH_TAB + 8'($urandom_range(0, 4));
		return c;
	endfunction

	function automatic logic [7:0] quoted_byte(logic [7:0] closer);
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == closer) c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic append_word();
		int kind;
		int len;
		logic [7:0] c;
		repeat ($urandom_range(1, 3)) begin
			kind = $urandom_range(0, 5);
			len = $urandom_range(0, 4);
			case (kind)
				3: begin
					put_byte(CH_SQ);
					repeat (len) put_byte(quoted_byte(CH_SQ));
					put_byte(CH_SQ);
				end
				4: begin
					put_byte(CH_DQ);
					repeat (len) put_byte(quoted_byte(CH_DQ));
					put_byte(CH_DQ);
				end
				5: begin
					put_byte(CH_BSL);
					put_byte(($urandom_range(0, 1) != 0) ? CH_SP : CH_BSL);
				end
				default: begin
					repeat (len + 1) begin
						c = 8'($urandom_range(0, 255));
						while (word_split_board_t::is_ws(c) || c == CH_SQ || c == CH_DQ
							|| c == CH_BSL)
							c = 8'($urandom_range(0, 255));
						put_byte(c);
					end
				end
			endcase
		end
	endtask

	// mostly well-formed lines, some that end in an error status, a few raw noise
	task automatic make_line();
		int kind;
		int words;
		int i;
		logic [7:0] c;
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 3) == 0) put_byte(blank_byte());
			words = $urandom_range(0, 5);
			for (i = 0; i < words; i++) begin
				if (i > 0) repeat ($urandom_range(1, 3)) put_byte(blank_byte());
				append_word();
			end
			if (kind < 5) begin
				if (words > 0 && $urandom_range(0, 1) != 0) put_byte(blank_byte());
				case (kind)
					2: begin
						put_byte(CH_BSL);
						c = 8'($urandom_range(0, 255));
						while (c == CH_SP || c == CH_BSL) c = 8'($urandom_range(0, 255));
						put_byte(c);
						if ($urandom_range(0, 1) != 0) append_word();
						if ($urandom_range(0, 1) != 0) begin
							put_byte(blank_byte());
							append_word();
						end
					end
					3: put_byte(CH_BSL);
					default: begin
						c = ($urandom_range(0, 1) != 0) ? CH_SQ : CH_DQ;
						put_byte(c);
						repeat ($urandom_range(0, 4)) put_byte(quoted_byte(c));
					end
				endcase
			end else if ($urandom_range(0, 3) == 0) put_byte(blank_byte());
			if (line_buf.size() == 0) put_byte(blank_byte());
		end
	endtask

	initial begin
		item_if.valid = 1'b0;
		item_if.in_char = '0;
		item_if.line_last = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		line_buf = {8'h61, CH_SP, 8'h62};
		flush_line();
		// empty quoted word
		line_buf = {CH_SQ, CH_SQ};
		flush_line();
		line_buf = {CH_DQ, 8'hFF, CH_DQ};
		flush_line();
		// escaped space then escaped backslash
		line_buf = {CH_BSL, CH_SP, CH_BSL, CH_BSL};
		flush_line();
		// unknown escape, rest of the line dropped
		line_buf = {CH_BSL, 8'h71, 8'h7A};
		flush_line();
		line_buf = {CH_BSL};
		flush_line();
		line_buf = {CH_SQ, 8'h80};
		flush_line();
		line_buf = {CH_DQ};
		flush_line();
		line_buf = {8'h00, CH_TAB, CH_CR};
		flush_line();

		while (n_accepted < RANDOM_ITEMS) begin
			if (!hold_done && n_accepted > 400) begin
				hold_req_cnt <= hold_req_cnt + 1;
				burst_left = 300;
				hold_done = 1'b1;
			end
			if (!drain_done && n_accepted > 800) begin
				item_if.valid <= 1'b0;
				// let the last request reach the scoreboard before counting
				@(posedge clk);
				while (board.pending() != 0) @(posedge clk);
				drain_done = 1'b1;
			end
			make_line();
			flush_line();
		end
		item_if.valid <= 1'b0;

		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d lines, %0d requests sent, %0d results compared",
			n_lines, n_accepted, board.n_checked);
		$display("%0d words closed, %0d lines ended in error, %0d mismatches",
			board.n_words, board.n_bad_lines, board.n_fail);
		if (board.n_fail == 0 && board.pending() == 0 && board.n_checked == n_accepted)
			$display("quoted_word_splitter verification clean");
		else
			$display("quoted_word_splitter verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/qws_pkg.sv
design/qws_in_if.sv
design/qws_out_if.sv
design/qws_lexer.sv
design/quoted_word_splitter.sv
verif/quoted_word_splitter_tb.sv
